@@ hdl/lobm_pkg.sv @@
// Shared types and constants of the order book matcher.
`default_nettype none
package lobm_pkg;
	localparam int PRICE_W = 32;
	localparam int QTY_W = 24;
	localparam int ID_W = 16;
	localparam int OWNER_W = 8;
	localparam int TIME_W = 16;
	localparam int MAX_RESULTS = 63;
	localparam int RES_CNT_W = 6;

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_CANCEL = 2'd1;
	localparam logic [1:0] MODE_MATCH = 2'd2;
	localparam logic [1:0] MODE_NOP = 2'd3;

	localparam logic KIND_TRADE = 1'b0;
	localparam logic KIND_REJECT = 1'b1;

	typedef struct packed {
		logic [1:0] op;
		logic side;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0] qty;
		logic [ID_W-1:0] id;
		logic [OWNER_W-1:0] owner;
		logic [TIME_W-1:0] tstep;
	} item_t;

	typedef struct packed {
		logic kind;
		logic [OWNER_W-1:0] buyer;
		logic [OWNER_W-1:0] seller;
		logic [ID_W-1:0] buy_order;
		logic [ID_W-1:0] sell_order;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0] qty;
		logic [TIME_W-1:0] tstep;
		logic last;
	} result_t;

	typedef struct packed {
		logic eval;
		logic ins;
		logic rem;
		logic pop;
		logic set_qty;
	} side_cmd_t;
endpackage
`default_nettype wire

@@ hdl/limit_order_book_matcher.sv @@
// Top level of the price-time priority order book matcher.
// Input channel (in_valid/in_ready) takes one request: add, cancel or match.
// Output channel (out_valid/out_ready) gives trade results and add rejections,
// with last marking the final result of a request.
// A two-entry queue sits in front of the engine, so requests are taken while
// the engine works or while a result waits in the output register.
// Zero-quantity adds and unknown modes are dropped at the queue.
// An add or cancel runs the evaluate and apply steps, a rejected add ends after
// evaluate, and a match takes one step per trade (at most 63 trades).
// Both sides compare all slots at once; inserts and removals shift all slots
// together, so the per-trade step is the limit on match throughput.
// When out_ready is low the pending result is held and the engine stalls once
// it has another result to emit; the queue keeps accepting until it is full.
// Reset empties both sides and the queue; slot contents are not cleared
// and no clearing pass is needed.
`default_nettype none
module limit_order_book_matcher #(
	parameter int SIDE_DEPTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] mode,
	input wire logic side,
	input wire logic [31:0] limit_price,
	input wire logic [23:0] order_quantity,
	input wire logic [15:0] order_number,
	input wire logic [7:0] trader,
	input wire logic [15:0] time_step,
	output logic out_valid,
	input wire logic out_ready,
	output logic kind,
	output logic [7:0] buyer,
	output logic [7:0] seller,
	output logic [15:0] buy_order,
	output logic [15:0] sell_order,
	output logic [31:0] trade_price,
	output logic [23:0] trade_quantity,
	output logic [15:0] trade_time,
	output logic last
);
	localparam int CW = $clog2(SIDE_DEPTH + 1);

	lobm_pkg::item_t in_item, q_item;
	lobm_pkg::result_t res;
	logic q_valid, q_pop;

	assign in_item.op = mode;
	assign in_item.side = side;
	assign in_item.price = limit_price;
	assign in_item.qty = order_quantity;
	assign in_item.id = order_number;
	assign in_item.owner = trader;
	assign in_item.tstep = time_step;

	lobm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
	);

	lobm_back #(.DEPTH(SIDE_DEPTH), .CW(CW)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop),
		.q_item(q_item), .out_valid(out_valid), .out_ready(out_ready), .out_res(res)
	);

	assign kind = res.kind;
	assign buyer = res.buyer;
	assign seller = res.seller;
	assign buy_order = res.buy_order;
	assign sell_order = res.sell_order;
	assign trade_price = res.price;
	assign trade_quantity = res.qty;
	assign trade_time = res.tstep;
	assign last = res.last;
endmodule
`default_nettype wire

@@ hdl/lobm_front.sv @@
// Request intake: classify items, drop no-ops, queue work for the engine.
`default_nettype none
module lobm_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire lobm_pkg::item_t in_item,
	output logic q_valid,
	input wire logic q_pop,
	output lobm_pkg::item_t q_item
);
	lobm_pkg::item_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] fill_q;
	logic keep;
	logic push;

	// drop unknown modes and zero-quantity adds at the door
	always_comb begin
		keep = 1'b0;
		case (in_item.op)
			lobm_pkg::MODE_ADD: keep = (in_item.qty != '0);
			lobm_pkg::MODE_CANCEL: keep = 1'b1;
			lobm_pkg::MODE_MATCH: keep = 1'b1;
			default: keep = 1'b0;
		endcase
	end

	assign in_ready = (fill_q != 2'd2);
	assign push = in_valid && in_ready && keep;
	assign q_valid = (fill_q != 2'd0);
	assign q_item = mem_q[rd_ptr_q];

	// write queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, q_pop})
				2'b10: fill_q <= fill_q + 2'd1;
				2'b01: fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hdl/lobm_side.sv @@
// One side of the book: a sorted row of order slots with shift insert and removal.
`default_nettype none
module lobm_side #(
	parameter int DEPTH = 32,
	parameter int CW = 6
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic ask_side,
	input wire lobm_pkg::side_cmd_t cmd,
	input wire logic [lobm_pkg::PRICE_W-1:0] new_price,
	input wire logic [lobm_pkg::QTY_W-1:0] new_qty,
	input wire logic [lobm_pkg::ID_W-1:0] new_id,
	input wire logic [lobm_pkg::OWNER_W-1:0] new_owner,
	input wire logic [lobm_pkg::QTY_W-1:0] head_qty_in,
	output logic [CW-1:0] count,
	output logic full,
	output logic hit,
	output logic [lobm_pkg::PRICE_W-1:0] head_price,
	output logic [lobm_pkg::PRICE_W-1:0] next_price,
	output logic [lobm_pkg::QTY_W-1:0] head_qty,
	output logic [lobm_pkg::ID_W-1:0] head_id,
	output logic [lobm_pkg::OWNER_W-1:0] head_owner
);
	logic [lobm_pkg::PRICE_W-1:0] price_q [DEPTH];
	logic [lobm_pkg::QTY_W-1:0] qty_q [DEPTH];
	logic [lobm_pkg::ID_W-1:0] id_q [DEPTH];
	logic [lobm_pkg::OWNER_W-1:0] owner_q [DEPTH];
	logic [DEPTH-1:0] ahead_q;
	logic [DEPTH-1:0] match_q;
	logic [DEPTH-1:0] pre_hit;
	logic [CW-1:0] count_q;

	assign count = count_q;
	assign full = (count_q == CW'(DEPTH));
	assign hit = |match_q;
	assign head_price = price_q[0];
	assign next_price = price_q[1];
	assign head_qty = qty_q[0];
	assign head_id = id_q[0];
	assign head_owner = owner_q[0];

	// mark the first match and every slot behind it
	always_comb begin
		pre_hit[0] = match_q[0];
		for (int i = 1; i < DEPTH; i++) begin
			pre_hit[i] = pre_hit[i-1] | match_q[i];
		end
	end

	// compare every live slot against the request
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			for (int i = 0; i < DEPTH; i++) begin
				ahead_q[i] <= (CW'(i) < count_q) &&
					(ask_side ? (price_q[i] <= new_price) : (price_q[i] >= new_price));
				match_q[i] <= (CW'(i) < count_q) && (id_q[i] == new_id);
			end
		end
	end

	// shift slots for insert, removal and head pop
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (cmd.ins) begin
				if (((i == 0) || ahead_q[(i == 0) ? 0 : i-1]) && !ahead_q[i]) begin
					price_q[i] <= new_price;
					qty_q[i] <= new_qty;
					id_q[i] <= new_id;
					owner_q[i] <= new_owner;
				end else if ((i > 0) && !ahead_q[(i == 0) ? 0 : i-1]) begin
					price_q[i] <= price_q[(i == 0) ? 0 : i-1];
					qty_q[i] <= qty_q[(i == 0) ? 0 : i-1];
					id_q[i] <= id_q[(i == 0) ? 0 : i-1];
					owner_q[i] <= owner_q[(i == 0) ? 0 : i-1];
				end
			end else if ((cmd.pop || (cmd.rem && pre_hit[i])) && (i < DEPTH-1)) begin
				price_q[i] <= price_q[(i < DEPTH-1) ? i+1 : i];
				qty_q[i] <= qty_q[(i < DEPTH-1) ? i+1 : i];
				id_q[i] <= id_q[(i < DEPTH-1) ? i+1 : i];
				owner_q[i] <= owner_q[(i < DEPTH-1) ? i+1 : i];
			end else if (cmd.set_qty && (i == 0)) begin
				qty_q[i] <= head_qty_in;
			end
		end
	end

	// track resting orders
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.pop || (cmd.rem && hit)) begin
			count_q <= count_q - CW'(1);
		end
	end
endmodule
`default_nettype wire

@@ hdl/lobm_back.sv @@
// Book engine: carries out adds, cancels and matching, and holds the result register.
`default_nettype none
module lobm_back #(
	parameter int DEPTH = 32,
	parameter int CW = 6
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_pop,
	input wire lobm_pkg::item_t q_item,
	output logic out_valid,
	input wire logic out_ready,
	output lobm_pkg::result_t out_res
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_APPLY = 2'd2;
	localparam logic [1:0] ST_MATCH = 2'd3;

	logic [1:0] state_q;
	lobm_pkg::item_t item_q;
	logic [lobm_pkg::RES_CNT_W-1:0] n_q;
	logic out_valid_q;
	lobm_pkg::result_t res_q;
	lobm_pkg::side_cmd_t bcmd, acmd;
	logic [CW-1:0] bcnt, acnt;
	logic bfull, afull, bhit, ahit;
	logic [lobm_pkg::PRICE_W-1:0] bp, ap, bp1, ap1;
	logic [lobm_pkg::QTY_W-1:0] bq, aq, tq;
	logic [lobm_pkg::ID_W-1:0] bid_id, ask_id;
	logic [lobm_pkg::OWNER_W-1:0] bown, aown;
	logic out_free, crossing, bdone, adone, next_cross, side_full;
	logic emit;
	lobm_pkg::result_t res_d;
	logic [lobm_pkg::PRICE_W-1:0] nbp, nap;
	logic [CW-1:0] nbcnt, nacnt;

	lobm_side #(.DEPTH(DEPTH), .CW(CW)) u_bid (
		.clk(clk), .arst_n(arst_n), .ask_side(1'b0), .cmd(bcmd),
		.new_price(item_q.price), .new_qty(item_q.qty), .new_id(item_q.id),
		.new_owner(item_q.owner), .head_qty_in(bq - tq), .count(bcnt),
		.full(bfull), .hit(bhit), .head_price(bp), .next_price(bp1),
		.head_qty(bq), .head_id(bid_id), .head_owner(bown)
	);

	lobm_side #(.DEPTH(DEPTH), .CW(CW)) u_ask (
		.clk(clk), .arst_n(arst_n), .ask_side(1'b1), .cmd(acmd),
		.new_price(item_q.price), .new_qty(item_q.qty), .new_id(item_q.id),
		.new_owner(item_q.owner), .head_qty_in(aq - tq), .count(acnt),
		.full(afull), .hit(ahit), .head_price(ap), .next_price(ap1),
		.head_qty(aq), .head_id(ask_id), .head_owner(aown)
	);

	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_res = res_q;
	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign side_full = item_q.side ? afull : bfull;

	// evaluate one cross of the best bid against the best ask
	always_comb begin
		tq = (bq < aq) ? bq : aq;
		crossing = (bcnt != '0) && (acnt != '0) && (bp >= ap) &&
			(n_q < lobm_pkg::RES_CNT_W'(lobm_pkg::MAX_RESULTS));
		bdone = (bq == tq);
		adone = (aq == tq);
		nbcnt = bcnt - CW'(bdone);
		nacnt = acnt - CW'(adone);
		nbp = bdone ? bp1 : bp;
		nap = adone ? ap1 : ap;
		next_cross = (n_q + lobm_pkg::RES_CNT_W'(1) <
			lobm_pkg::RES_CNT_W'(lobm_pkg::MAX_RESULTS)) &&
			(nbcnt != '0) && (nacnt != '0) && (nbp >= nap);
	end

	// drive side commands and the result
	always_comb begin
		bcmd = '0;
		acmd = '0;
		emit = 1'b0;
		res_d = '0;
		res_d.tstep = item_q.tstep;
		res_d.last = 1'b1;
		case (state_q)
			ST_EVAL: begin
				if (item_q.op == lobm_pkg::MODE_ADD && side_full) begin
					emit = out_free;
					res_d.kind = lobm_pkg::KIND_REJECT;
					res_d.price = item_q.price;
					res_d.qty = item_q.qty;
					if (item_q.side) begin
						res_d.seller = item_q.owner;
						res_d.sell_order = item_q.id;
					end else begin
						res_d.buyer = item_q.owner;
						res_d.buy_order = item_q.id;
					end
				end else begin
					bcmd.eval = 1'b1;
					acmd.eval = 1'b1;
				end
			end
			ST_APPLY: begin
				if (item_q.op == lobm_pkg::MODE_ADD) begin
					bcmd.ins = !item_q.side;
					acmd.ins = item_q.side;
				end else begin
					bcmd.rem = 1'b1;
					acmd.rem = !bhit && ahit;
				end
			end
			ST_MATCH: begin
				if (crossing && out_free) begin
					emit = 1'b1;
					res_d.kind = lobm_pkg::KIND_TRADE;
					res_d.buyer = bown;
					res_d.seller = aown;
					res_d.buy_order = bid_id;
					res_d.sell_order = ask_id;
					res_d.price = ap;
					res_d.qty = tq;
					res_d.last = !next_cross;
					bcmd.pop = bdone;
					bcmd.set_qty = !bdone;
					acmd.pop = adone;
					acmd.set_qty = !adone;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// latch the request being worked on and the emitted result
	always_ff @(posedge clk) begin
		if (q_pop) item_q <= q_item;
		if (emit) res_q <= res_d;
	end

	// sequence the engine and hold the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					n_q <= '0;
					if (q_valid) begin
						state_q <= (q_item.op == lobm_pkg::MODE_MATCH) ? ST_MATCH : ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (item_q.op == lobm_pkg::MODE_ADD && side_full) begin
						if (out_free) state_q <= ST_IDLE;
					end else begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: state_q <= ST_IDLE;
				ST_MATCH: begin
					if (!crossing) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						n_q <= n_q + lobm_pkg::RES_CNT_W'(1);
						if (!next_cross) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(bcnt <= CW'(DEPTH)) && (acnt <= CW'(DEPTH)))
		else $error("side count above depth");
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= lobm_pkg::RES_CNT_W'(lobm_pkg::MAX_RESULTS))
		else $error("trade cap exceeded");
	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && res_d.kind == lobm_pkg::KIND_REJECT) |-> side_full)
		else $error("reject on a side with room");
	a_trade_crosses: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && res_d.kind == lobm_pkg::KIND_TRADE) |-> (bp >= ap && tq != '0))
		else $error("trade without a cross");
`endif
endmodule
`default_nettype wire

@@ bench/limit_order_book_matcher_test.sv @@
// Self-checking bench for the price-time priority order book matcher.
`timescale 1ns / 100ps
`default_nettype none
module limit_order_book_matcher_test;
	localparam int DEPTH = 32;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [lobm_pkg::PRICE_W-1:0] price;
		logic [lobm_pkg::QTY_W-1:0] qty;
		logic [lobm_pkg::ID_W-1:0] id;
		logic [lobm_pkg::OWNER_W-1:0] owner;
	} order_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] mode = lobm_pkg::MODE_ADD;
	logic side = 1'b0;
	logic [31:0] limit_price = '0;
	logic [23:0] order_quantity = '0;
	logic [15:0] order_number = '0;
	logic [7:0] trader = '0;
	logic [15:0] time_step = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic kind;
	logic [7:0] buyer, seller;
	logic [15:0] buy_order, sell_order;
	logic [31:0] trade_price;
	logic [23:0] trade_quantity;
	logic [15:0] trade_time;
	logic last;

	// resting orders as the block should hold them
	order_t bids[$];
	order_t asks[$];
	lobm_pkg::result_t trades_due[$];

	int mismatches = 0;
	int idle_cycles = 0;
	int hold_off = 0;
	bit quiet = 1'b0;

	limit_order_book_matcher #(.SIDE_DEPTH(DEPTH)) uut (.*);

	always #5 clk = ~clk;

	// work out what one accepted request produces and update the book
	task automatic book_apply(input lobm_pkg::item_t it);
		order_t o;
		lobm_pkg::result_t r;
		int pos;
		int n;
		logic [lobm_pkg::QTY_W-1:0] tq;
		bit done;
		o.price = it.price;
		o.qty = it.qty;
		o.id = it.id;
		o.owner = it.owner;
		case (it.op)
			lobm_pkg::MODE_ADD: begin
				if (it.qty != 0) begin
					if ((it.side ? asks.size() : bids.size()) >= DEPTH) begin
						r = '0;
						r.kind = lobm_pkg::KIND_REJECT;
						if (it.side) begin
							r.seller = it.owner;
							r.sell_order = it.id;
						end else begin
							r.buyer = it.owner;
							r.buy_order = it.id;
						end
						r.price = it.price;
						r.qty = it.qty;
						r.tstep = it.tstep;
						r.last = 1'b1;
						trades_due.push_back(r);
					end else if (it.side) begin
						pos = 0;
						while (pos < asks.size() && asks[pos].price <= it.price) pos++;
						asks.insert(pos, o);
					end else begin
						pos = 0;
						while (pos < bids.size() && bids[pos].price >= it.price) pos++;
						bids.insert(pos, o);
					end
				end
			end
			lobm_pkg::MODE_CANCEL: begin
				done = 1'b0;
				for (int i = 0; i < bids.size() && !done; i++) begin
					if (bids[i].id == it.id) begin
						bids.delete(i);
						done = 1'b1;
					end
				end
				for (int i = 0; i < asks.size() && !done; i++) begin
					if (asks[i].id == it.id) begin
						asks.delete(i);
						done = 1'b1;
					end
				end
			end
			lobm_pkg::MODE_MATCH: begin
				n = 0;
				while (n < lobm_pkg::MAX_RESULTS && bids.size() > 0 && asks.size() > 0 &&
						bids[0].price >= asks[0].price) begin
					tq = (bids[0].qty < asks[0].qty) ? bids[0].qty : asks[0].qty;
					r.kind = lobm_pkg::KIND_TRADE;
					r.buyer = bids[0].owner;
					r.seller = asks[0].owner;
					r.buy_order = bids[0].id;
					r.sell_order = asks[0].id;
					r.price = asks[0].price;
					r.qty = tq;
					r.tstep = it.tstep;
					r.last = 1'b0;
					trades_due.push_back(r);
					n++;
					bids[0].qty -= tq;
					asks[0].qty -= tq;
					if (bids[0].qty == 0) bids.delete(0);
					if (asks[0].qty == 0) asks.delete(0);
				end
				if (n > 0) trades_due[trades_due.size()-1].last = 1'b1;
			end
			default: ;
		endcase
	endtask

	// offer one request and hold it until taken; drop valid only while idling
	task automatic send_request(input lobm_pkg::item_t it, input bit may_idle);
		while (may_idle && !quiet && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= it.op;
		side <= it.side;
		limit_price <= it.price;
		order_quantity <= it.qty;
		order_number <= it.id;
		trader <= it.owner;
		time_step <= it.tstep;
		do @(posedge clk); while (!in_ready);
		book_apply(it);
	endtask

	function automatic lobm_pkg::item_t make_item(logic [1:0] op, logic sd, logic [31:0] p,
			logic [23:0] q, logic [15:0] id, logic [7:0] ow, logic [15:0] t);
		lobm_pkg::item_t it;
		it.op = op;
		it.side = sd;
		it.price = p;
		it.qty = q;
		it.id = id;
		it.owner = ow;
		it.tstep = t;
		return it;
	endfunction

	function automatic lobm_pkg::item_t random_item(int price_span);
		lobm_pkg::item_t it;
		int pick;
		it.side = 1'($urandom_range(1));
		it.price = (price_span > 0) ? 32'd1000 + 32'($urandom_range(price_span)) : $urandom;
		it.qty = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(1, 60));
		if ($urandom_range(29) == 0) it.qty = '0;
		it.id = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(40));
		it.owner = 8'($urandom);
		it.tstep = 16'($urandom);
		pick = $urandom_range(99);
		if (pick < 55) it.op = lobm_pkg::MODE_ADD;
		else if (pick < 70) it.op = lobm_pkg::MODE_CANCEL;
		else if (pick < 97) it.op = lobm_pkg::MODE_MATCH;
		else it.op = lobm_pkg::MODE_NOP;
		return it;
	endfunction

	// hold the sender until every expected result has come
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (trades_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// receiver: random stalls unless quiet, plus a forced hold-off
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 38);
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		lobm_pkg::result_t got, want;
		if (out_valid && out_ready) begin
			got = {kind, buyer, seller, buy_order, sell_order, trade_price,
				trade_quantity, trade_time, last};
			if (trades_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
			end else begin
				want = trades_due[0];
				trades_due.delete(0);
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic test_extremes();
		send_request(make_item(lobm_pkg::MODE_ADD, 1'b0, 32'hFFFF_FFFF, 24'hFF_FFFF,
			16'hFFFF, 8'hFF, 16'hFFFF), 1'b0);
		send_request(make_item(lobm_pkg::MODE_ADD, 1'b1, 32'h0, 24'h1, 16'h0, 8'h0,
			16'h0), 1'b0);
		send_request(make_item(lobm_pkg::MODE_ADD, 1'b1, 32'h0, 24'h0, 16'h5, 8'h1,
			16'h0), 1'b0);
		send_request(make_item(lobm_pkg::MODE_NOP, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF,
			16'hFFFF, 8'hFF, 16'hFFFF), 1'b0);
		send_request(make_item(lobm_pkg::MODE_ADD, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF,
			16'hAAAA, 8'h55, 16'h1), 1'b0);
		send_request(make_item(lobm_pkg::MODE_MATCH, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF,
			16'h1234, 8'hFF, 16'h8000), 1'b0);
		send_request(make_item(lobm_pkg::MODE_MATCH, 1'b0, 0, 0, 0, 0, 16'h7FFF), 1'b0);
		wait_drained();
	endtask

	task automatic test_priority_and_cancel();
		send_request(make_item(lobm_pkg::MODE_ADD, 1'b0, 100, 10, 1, 1, 0), 1'b0);
		send_request(make_item(lobm_pkg::MODE_ADD, 1'b0, 100, 10, 2, 2, 0), 1'b0);
		send_request(make_item(lobm_pkg::MODE_ADD, 1'b0, 100, 10, 2, 3, 0), 1'b0);
		send_request(make_item(lobm_pkg::MODE_ADD, 1'b1, 99, 5, 2, 4, 0), 1'b0);
		send_request(make_item(lobm_pkg::MODE_CANCEL, 1'b0, 0, 0, 2, 0, 0), 1'b0);
		send_request(make_item(lobm_pkg::MODE_CANCEL, 1'b0, 0, 0, 999, 0, 0), 1'b0);
		send_request(make_item(lobm_pkg::MODE_ADD, 1'b1, 101, 30, 7, 5, 0), 1'b0);
		send_request(make_item(lobm_pkg::MODE_MATCH, 1'b0, 0, 0, 0, 0, 3), 1'b0);
		wait_drained();
	endtask

	task automatic test_full_side_and_cap();
		for (int i = 0; i <= DEPTH; i++)
			send_request(make_item(lobm_pkg::MODE_ADD, 1'b0, 500, 1, 16'(i), 8'(i), 0),
				1'b1);
		for (int i = 0; i <= DEPTH; i++)
			send_request(make_item(lobm_pkg::MODE_ADD, 1'b1, 32'(400 + i), 1,
				16'(100 + i), 8'(i), 0), 1'b1);
		send_request(make_item(lobm_pkg::MODE_MATCH, 1'b0, 0, 0, 0, 0, 9), 1'b1);
		send_request(make_item(lobm_pkg::MODE_MATCH, 1'b0, 0, 0, 0, 0, 10), 1'b1);
		wait_drained();
	endtask

	task automatic test_backpressure();
		hold_off = 300;
		for (int i = 0; i < 12; i++)
			send_request(make_item(i % 3 == 2 ? lobm_pkg::MODE_MATCH : lobm_pkg::MODE_ADD,
				i[0], 700, 3, 16'(200 + i), 8'(i), 16'(i)), 1'b0);
		wait_drained();
	endtask

	task automatic test_random();
		for (int i = 0; i < 374; i++) begin
			quiet = (i >= 150 && i < 230);
			send_request(random_item(i % 50 == 7 ? 0 : 40), 1'b1);
			if (i % 120 == 119) wait_drained();
		end
		quiet = 1'b0;
		send_request(make_item(lobm_pkg::MODE_MATCH, 1'b0, 0, 0, 0, 0, 1), 1'b1);
		wait_drained();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_priority_and_cancel();
		test_full_side_and_cap();
		test_backpressure();
		test_random();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && trades_due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
